### rtl/core/llfm_pkg.sv
// Shared types and constants of the LED layer frame mixer.
// Used by the shared divide unit and by the top level; depends on nothing.
`default_nettype none

package llfm_pkg;

  // Damping factor, unsigned 10.8 fixed point.
  localparam int FACTOR_W = 18;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 18'd256;
  localparam logic [FACTOR_W-1:0] FACTOR_HIT = 18'd256000;

  // Shared divide unit datapath widths. The mixed byte never exceeds 255,
  // so eight quotient bits suffice.
  localparam int REM_W  = 22;
  localparam int DEN_W  = 26;
  localparam int QUO_W  = 8;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] MIX_STEPS = 5'd8;

  // Decay by 0.9 as a reciprocal multiplication: factor * 9 * ceil(2^25 / 10)
  // shifted right by 25 equals floor(factor * 9 / 10) over the factor's range.
  localparam int                     DECAY_MUL_W = 25;
  localparam int                     DECAY_SHIFT = 25;
  localparam logic [DECAY_MUL_W-1:0] DECAY_MUL   = 25'd30198996;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

### rtl/core/led_layer_frame_mixer_core.sv
// Top level of the LED layer frame mixer: sequencer, state and output register.
// Depends on llfm_pkg, llfm_div_unit and llfm_frame_store.
//
//   Channel   Signals                                          Direction
//   in_       valid/ready, op, layer_bytes, read_index, last   in
//   out_      valid/ready, pixel_value, passed_through         out
//   cfg_      we, index, wdata (music_mode, running_mask)      in
//
// A load runs from transfer through S_MIX_GO, the 8-step mix division on
// the shared divide unit (S_MIX, skipped when no layer runs) and S_FIN to
// ready again; the first load of a frame runs the factor decay (S_DECAY)
// ahead of the mix. A read runs through the registered store read (S_READ)
// and its response state to ready again when the output register is free;
// a read stalls there while an earlier result still waits on out_ready.
// Reset is synchronous; the stores are not cleared and hold garbage until
// written.
`default_nettype none

module led_layer_frame_mixer_core
  import llfm_pkg::*;
#(
  parameter int LAYERS      = 4,
  parameter int FRAME_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_layer_bytes,
  input  wire logic [9:0]  in_read_index,
  input  wire logic        in_frame_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_pixel_value,
  output logic             out_passed_through,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int WP_W   = $clog2(FRAME_BYTES + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_MUSIC_MODE   = 1'b0;
  localparam logic CFG_RUNNING_MASK = 1'b1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECAY  = 3'd1;
  localparam logic [2:0] S_MIX_GO = 3'd2;
  localparam logic [2:0] S_MIX    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic                music_mode_r, music_mode_nxt;
  logic [3:0]          running_mask_r, running_mask_nxt;
  logic [WP_W-1:0]     wp_r, wp_nxt;
  logic [FACTOR_W-1:0] factor_r, factor_nxt;
  logic                hit_r, hit_nxt;
  logic                passed_r, passed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_pixel_r, out_pixel_nxt;
  logic                out_passed_r, out_passed_nxt;
  logic [31:0]         bytes_r, bytes_nxt;
  logic                last_r, last_nxt;
  logic [ADDR_W-1:0]   raddr_r, raddr_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [7:0]          mix_val_r, mix_val_nxt;

  logic                              accept;
  logic [9:0]                        sum;
  logic [2:0]                        count;
  logic [FACTOR_W-1:0]               factor_eff;
  logic                              l0_hit;
  logic [18:0]                       mix_den;
  logic [FACTOR_W+DECAY_MUL_W-1:0]   decay_prod;
  div_ctl_t                          div_ctl;
  div_sts_t                          div_sts;
  logic [REM_W-1:0]                  div_num;
  logic [DEN_W-1:0]                  div_den;
  logic [QUO_W-1:0]                  div_quo;
  logic                              st_we;
  logic                              st_re;
  logic [7:0]                        st_rmix;
  logic [7:0]                        st_rl0;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Sum and count of the running layers; lanes at or above LAYERS stay out.
  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < LAYERS && running_mask_r[i]) begin
        sum   = sum + {2'b00, bytes_r[8*i +: 8]};
        count = count + 3'd1;
      end
    end
  end

  assign l0_hit     = music_mode_r && (bytes_r[7:0] != 8'd0);
  assign factor_eff = l0_hit ? FACTOR_HIT : factor_r;
  assign mix_den    = {8'd0, count, 8'd0} + {1'b0, factor_eff};
  assign decay_prod = {{DECAY_MUL_W{1'b0}}, factor_r} * {{FACTOR_W{1'b0}}, DECAY_MUL};

  always_comb begin
    state_nxt        = state_r;
    music_mode_nxt   = music_mode_r;
    running_mask_nxt = running_mask_r;
    wp_nxt           = wp_r;
    factor_nxt       = factor_r;
    hit_nxt          = hit_r;
    passed_nxt       = passed_r;
    out_valid_nxt    = out_valid_r;
    out_pixel_nxt    = out_pixel_r;
    out_passed_nxt   = out_passed_r;
    bytes_nxt        = bytes_r;
    last_nxt         = last_r;
    raddr_nxt        = raddr_r;
    rd_ok_nxt        = rd_ok_r;
    mix_val_nxt      = mix_val_r;
    div_ctl.start    = 1'b0;
    div_ctl.steps    = MIX_STEPS;
    div_num          = {4'b0000, sum, 8'd0};
    div_den          = {mix_den, 7'd0};
    st_we            = 1'b0;
    st_re            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_MUSIC_MODE:   music_mode_nxt   = cfg_wdata[0];
        CFG_RUNNING_MASK: running_mask_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bytes_nxt = in_layer_bytes;
          last_nxt  = in_frame_last;
          raddr_nxt = in_read_index[ADDR_W-1:0];
          rd_ok_nxt = ({1'b0, in_read_index} < 11'(FRAME_BYTES));
          if (in_op == OP_READ) begin
            state_nxt = S_READ;
          end else if (wp_r == '0) begin
            // First byte of a frame: decay the factor before mixing.
            state_nxt = S_DECAY;
          end else begin
            state_nxt = S_MIX_GO;
          end
        end
      end
      S_DECAY: begin
        factor_nxt = FACTOR_W'(decay_prod >> DECAY_SHIFT);
        state_nxt  = S_MIX_GO;
      end
      S_MIX_GO: begin
        if (l0_hit) begin
          hit_nxt    = 1'b1;
          factor_nxt = FACTOR_HIT;
        end
        if (count == 3'd0) begin
          mix_val_nxt = 8'd0;
          state_nxt   = S_FIN;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = S_MIX;
        end
      end
      S_MIX: begin
        if (div_sts.done) begin
          mix_val_nxt = div_quo[7:0];
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (wp_r < WP_W'(FRAME_BYTES)) begin
          st_we  = 1'b1;
          wp_nxt = wp_r + 1'b1;
        end
        if (last_r) begin
          passed_nxt = hit_r;
          hit_nxt    = 1'b0;
          wp_nxt     = '0;
        end
        state_nxt = S_IDLE;
      end
      S_READ: begin
        st_re     = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_passed_nxt = passed_r;
          if (!rd_ok_r) begin
            out_pixel_nxt = 8'd0;
          end else if (passed_r) begin
            out_pixel_nxt = st_rl0;
          end else begin
            out_pixel_nxt = st_rmix;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      music_mode_r   <= 1'b0;
      running_mask_r <= 4'd15;
      wp_r           <= '0;
      factor_r       <= FACTOR_ONE;
      hit_r          <= 1'b0;
      passed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      music_mode_r   <= music_mode_nxt;
      running_mask_r <= running_mask_nxt;
      wp_r           <= wp_nxt;
      factor_r       <= factor_nxt;
      hit_r          <= hit_nxt;
      passed_r       <= passed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_pixel_r  <= out_pixel_nxt;
    out_passed_r <= out_passed_nxt;
    bytes_r      <= bytes_nxt;
    last_r       <= last_nxt;
    raddr_r      <= raddr_nxt;
    rd_ok_r      <= rd_ok_nxt;
    mix_val_r    <= mix_val_nxt;
  end

  llfm_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  llfm_frame_store #(
    .FRAME_BYTES (FRAME_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (wp_r[ADDR_W-1:0]),
    .wmix  (mix_val_r),
    .wl0   (bytes_r[7:0]),
    .re    (st_re),
    .raddr (raddr_r),
    .rmix  (st_rmix),
    .rl0   (st_rl0)
  );

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = out_pixel_r;
  assign out_passed_through = out_passed_r;

`ifndef SYNTHESIS
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_MIX))
    else $error("divide unit finished outside the mix state");

  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_sts.busy)
    else $error("input ready while the divide unit is busy");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_W'(FRAME_BYTES))
    else $error("write position ran past the frame size");

  a_factor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    factor_r <= FACTOR_HIT)
    else $error("damping factor above its ceiling");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result presented without a read response");
`endif

endmodule

`default_nettype wire

### rtl/core/llfm_div_unit.sv
// Shared restoring divide unit: one compare and subtract per cycle.
// Depends on llfm_pkg for widths and the control and status structs.
`default_nettype none

module llfm_div_unit
  import llfm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_ctl_t         ctl,
  input  wire logic [REM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output div_sts_t              sts,
  output logic      [QUO_W-1:0] quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              take;

  // The divisor arrives pre-shifted to the top quotient bit and walks right.
  assign take = ({{(DEN_W-REM_W){1'b0}}, rem_r} >= den_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.steps;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (take) begin
        rem_nxt = rem_r - den_r[REM_W-1:0];
      end
      quo_nxt = {quo_r[QUO_W-2:0], take};
      den_nxt = {1'b0, den_r[DEN_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

`default_nettype wire

### rtl/core/llfm_frame_store.sv
// Frame stores: the mixed bytes and the layer-0 bytes, one write and one
// registered read port shared by both. Depends on nothing.
`default_nettype none

module llfm_frame_store #(
  parameter int FRAME_BYTES = 1024,
  parameter int ADDR_W      = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wmix,
  input  wire logic [7:0]        wl0,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rmix,
  output logic      [7:0]        rl0
);

  logic [7:0] mix_mem [FRAME_BYTES];
  logic [7:0] l0_mem  [FRAME_BYTES];
  logic [7:0] rmix_r;
  logic [7:0] rl0_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mix_mem[waddr] <= wmix;
      l0_mem[waddr]  <= wl0;
    end
    if (re) begin
      rmix_r <= mix_mem[raddr];
      rl0_r  <= l0_mem[raddr];
    end
  end

  assign rmix = rmix_r;
  assign rl0  = rl0_r;

endmodule

`default_nettype wire
